/* src/qte_pkg.sv */
// shared types, constants and helpers of the quaternion to euler converter
package qte_pkg;

  localparam int QUAT_W    = 16;
  localparam int PROD_W    = 32;
  localparam int SUM_W     = 34;
  localparam int SPS_W     = 29;
  localparam int MAG_W     = 28;
  localparam int SQ_W      = 56;
  localparam int ISQ_NW    = 57;
  localparam int ISQ_RW    = 58;
  localparam int ROOT_W    = 29;
  localparam int ISQ_STEPS = 29;
  localparam int OPW       = 37;
  localparam int ZW        = 34;
  localparam int ANG_W     = 16;
  localparam int PITCH_W   = 15;
  localparam int ATAN_LEN  = 24;

  localparam logic signed [ZW-1:0]    PI_Q30      = 34'sd3373259426;
  localparam logic signed [SUM_W-1:0] ONE_Q28     = 34'sd268435456;
  localparam logic signed [ANG_W-1:0] PI_Q13      = 16'sd25736;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q13 = 16'sd12868;

  localparam logic [29:0] ATAN_TAB [0:ATAN_LEN-1] = '{
    30'd843314857, 30'd497837829, 30'd263043836, 30'd133525158, 30'd67021686,
    30'd33543515, 30'd16775850, 30'd8388437, 30'd4194282, 30'd2097149,
    30'd1048575, 30'd524287, 30'd262143, 30'd131071, 30'd65535, 30'd32767,
    30'd16383, 30'd8191, 30'd4095, 30'd2047, 30'd1023, 30'd511, 30'd255, 30'd127
  };

  typedef logic signed [QUAT_W-1:0] quat_t;
  typedef logic signed [ANG_W-1:0] angle_t;
  typedef logic signed [PITCH_W-1:0] pitch_t;

  typedef struct packed {
    logic signed [SPS_W-1:0] sps;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] cy;
    logic signed [SUM_W-1:0] sr;
    logic signed [SUM_W-1:0] cr;
    logic clamp;
    logic dir;
  } side_t;

  typedef struct packed {
    logic clamp;
    logic dir;
  } flag_t;

  function automatic angle_t to_q13(input logic signed [ZW-1:0] a, input angle_t lim);
    logic signed [ZW:0] s;
    angle_t r;
    s = ($signed({a[ZW-1], a}) + (ZW+1)'(65536)) >>> 17;
    if (s > lim) begin
      r = lim;
    end else if (s < -lim) begin
      r = -lim;
    end else begin
      r = ANG_W'(s);
    end
    return r;
  endfunction

endpackage

/* src/qte_in_if.sv */
// quaternion input channel
interface qte_in_if;
  import qte_pkg::*;
  logic  valid;
  logic  ready;
  quat_t quat_x;
  quat_t quat_y;
  quat_t quat_z;
  quat_t quat_w;
  modport source (output valid, output quat_x, output quat_y, output quat_z,
                  output quat_w, input ready);
  modport sink (input valid, input quat_x, input quat_y, input quat_z,
                input quat_w, output ready);
endinterface

/* src/qte_out_if.sv */
// euler angle result channel
interface qte_out_if;
  import qte_pkg::*;
  logic   valid;
  logic   ready;
  angle_t roll_angle;
  pitch_t pitch_angle;
  angle_t yaw_angle;
  logic   pitch_clamped;
  modport source (output valid, output roll_angle, output pitch_angle,
                  output yaw_angle, output pitch_clamped, input ready);
  modport sink (input valid, input roll_angle, input pitch_angle,
                input yaw_angle, input pitch_clamped, output ready);
endinterface

/* src/qte_isqrt.sv */
// pipelined bitwise integer square root, one root bit per stage
module qte_isqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [qte_pkg::ISQ_NW-1:0] n_in,
  output logic [qte_pkg::ROOT_W-1:0] root_out
);
  import qte_pkg::*;

  logic [ISQ_NW-1:0] rem_r   [0:ISQ_STEPS-1];
  logic [ISQ_RW-1:0] root_r  [0:ISQ_STEPS-1];
  logic [ISQ_NW-1:0] rem_nxt [0:ISQ_STEPS-1];
  logic [ISQ_RW-1:0] root_nxt[0:ISQ_STEPS-1];

  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
    localparam int B = 2 * (ISQ_STEPS - 1 - k);
    logic [ISQ_NW-1:0] rem_in;
    logic [ISQ_RW-1:0] root_in;
    logic [ISQ_RW-1:0] trial;
    if (k == 0) begin : g_first
      assign rem_in  = n_in;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end
    assign trial = root_in + (ISQ_RW'(1) << B);
    always_comb begin
      if ({1'b0, rem_in} >= trial) begin
        rem_nxt[k]  = rem_in - ISQ_NW'(trial);
        root_nxt[k] = (root_in >> 1) + (ISQ_RW'(1) << B);
      end else begin
        rem_nxt[k]  = rem_in;
        root_nxt[k] = root_in >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ISQ_STEPS; k++) begin
        rem_r[k]  <= rem_nxt[k];
        root_r[k] <= root_nxt[k];
      end
    end
  end

  assign root_out = root_r[ISQ_STEPS-1][ROOT_W-1:0];

endmodule

/* src/qte_cordic.sv */
// pipelined vectoring cordic giving atan2 in q.30 radians
module qte_cordic #(
  parameter int ITER = 16
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [qte_pkg::OPW-1:0] x_in,
  input  logic signed [qte_pkg::OPW-1:0] y_in,
  output logic signed [qte_pkg::ZW-1:0]  z_out
);
  import qte_pkg::*;

  logic signed [OPW-1:0] x_r   [0:ITER];
  logic signed [OPW-1:0] y_r   [0:ITER];
  logic signed [ZW-1:0]  z_r   [0:ITER];
  logic                  zf_r  [0:ITER];
  logic signed [OPW-1:0] x_nxt [0:ITER];
  logic signed [OPW-1:0] y_nxt [0:ITER];
  logic signed [ZW-1:0]  z_nxt [0:ITER];

  // quadrant fold
  always_comb begin
    if (x_in[OPW-1]) begin
      x_nxt[0] = -x_in;
      y_nxt[0] = -y_in;
      z_nxt[0] = y_in[OPW-1] ? -PI_Q30 : PI_Q30;
    end else begin
      x_nxt[0] = x_in;
      y_nxt[0] = y_in;
      z_nxt[0] = '0;
    end
  end

  for (genvar i = 0; i < ITER; i++) begin : g_it
    logic signed [OPW-1:0] xs;
    logic signed [OPW-1:0] ys;
    logic signed [ZW-1:0]  at;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;
    assign at = $signed({{(ZW-30){1'b0}}, ATAN_TAB[i]});
    always_comb begin
      if (!y_r[i][OPW-1]) begin
        x_nxt[i+1] = x_r[i] + ys;
        y_nxt[i+1] = y_r[i] - xs;
        z_nxt[i+1] = z_r[i] + at;
      end else begin
        x_nxt[i+1] = x_r[i] - ys;
        y_nxt[i+1] = y_r[i] + xs;
        z_nxt[i+1] = z_r[i] - at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zf_r[0] <= (x_in == '0) && (y_in == '0);
      for (int k = 0; k <= ITER; k++) begin
        x_r[k] <= x_nxt[k];
        y_r[k] <= y_nxt[k];
        z_r[k] <= z_nxt[k];
      end
      for (int k = 1; k <= ITER; k++) begin
        zf_r[k] <= zf_r[k-1];
      end
    end
  end

  assign z_out = zf_r[ITER] ? '0 : z_r[ITER];

endmodule

/* src/quaternion_to_euler_core.sv */
// quaternion to zyx euler angle converter, top level
// throughput: one beat per cycle; the whole pipeline advances together and
// holds when the result register is full and not taken
// the depth is set by the 29-stage square root plus one stage per cordic step
// reset clears all valid bits; payload registers are not reset
module quaternion_to_euler_core #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  qte_in_if.sink    in_chan,
  qte_out_if.source out_chan
);
  import qte_pkg::*;

  localparam int CN    = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
  localparam int CLAT  = CN + 1;
  localparam int DEPTH = 4 + ISQ_STEPS + CLAT;

  logic en;
  logic vld_r [0:DEPTH-1];
  logic out_valid_r;

  assign en            = !out_valid_r || out_chan.ready;
  assign in_chan.ready = en;

  // stage 1: input capture
  quat_t qx_r, qy_r, qz_r, qw_r;
  // stage 2: products
  logic signed [PROD_W-1:0] wy_r, zx_r, wz_r, xy_r, yy_r, zz_r, wx_r, yz_r, xx_r;
  // stage 3: sums
  side_t s3_r;
  side_t s3_nxt;
  logic signed [SUM_W-1:0] sp;
  // stage 4: square
  side_t s4_r;
  logic [SQ_W-1:0] sq_r;
  logic [MAG_W-1:0] mag;

  side_t side_r [0:ISQ_STEPS-1];
  flag_t flag_r [0:CLAT-1];

  logic [ROOT_W-1:0] root;
  logic signed [ZW-1:0] zp, zy, zr;
  side_t sd;

  assign sp = (SUM_W'(wy_r) - SUM_W'(zx_r)) <<< 1;

  always_comb begin
    s3_nxt.sy    = (SUM_W'(wz_r) + SUM_W'(xy_r)) <<< 1;
    s3_nxt.cy    = ONE_Q28 - ((SUM_W'(yy_r) + SUM_W'(zz_r)) <<< 1);
    s3_nxt.sr    = (SUM_W'(wx_r) + SUM_W'(yz_r)) <<< 1;
    s3_nxt.cr    = ONE_Q28 - ((SUM_W'(xx_r) + SUM_W'(yy_r)) <<< 1);
    s3_nxt.clamp = (sp >= ONE_Q28) || (sp <= -ONE_Q28);
    s3_nxt.dir   = !sp[SUM_W-1];
    s3_nxt.sps   = s3_nxt.clamp ? '0 : sp[SPS_W-1:0];
  end

  assign mag = s3_r.sps[SPS_W-1] ? MAG_W'(-s3_r.sps) : MAG_W'(s3_r.sps);

  always_ff @(posedge clk) begin
    if (en) begin
      qx_r <= in_chan.quat_x;
      qy_r <= in_chan.quat_y;
      qz_r <= in_chan.quat_z;
      qw_r <= in_chan.quat_w;
      wy_r <= qw_r * qy_r;
      zx_r <= qz_r * qx_r;
      wz_r <= qw_r * qz_r;
      xy_r <= qx_r * qy_r;
      yy_r <= qy_r * qy_r;
      zz_r <= qz_r * qz_r;
      wx_r <= qw_r * qx_r;
      yz_r <= qy_r * qz_r;
      xx_r <= qx_r * qx_r;
      s3_r <= s3_nxt;
      s4_r <= s3_r;
      sq_r <= mag * mag;
      side_r[0] <= s4_r;
      for (int k = 1; k < ISQ_STEPS; k++) begin
        side_r[k] <= side_r[k-1];
      end
      flag_r[0] <= '{clamp: side_r[ISQ_STEPS-1].clamp, dir: side_r[ISQ_STEPS-1].dir};
      for (int k = 1; k < CLAT; k++) begin
        flag_r[k] <= flag_r[k-1];
      end
    end
  end

  qte_isqrt u_isqrt (
    .clk      (clk),
    .en       (en),
    .n_in     ((ISQ_NW'(1) << SQ_W) - {1'b0, sq_r}),
    .root_out (root)
  );

  assign sd = side_r[ISQ_STEPS-1];

  qte_cordic #(.ITER(CN)) u_cordic_pitch (
    .clk   (clk),
    .en    (en),
    .x_in  ($signed({{(OPW-ROOT_W){1'b0}}, root})),
    .y_in  (OPW'(sd.sps)),
    .z_out (zp)
  );

  qte_cordic #(.ITER(CN)) u_cordic_yaw (
    .clk   (clk),
    .en    (en),
    .x_in  (OPW'(sd.cy)),
    .y_in  (OPW'(sd.sy)),
    .z_out (zy)
  );

  qte_cordic #(.ITER(CN)) u_cordic_roll (
    .clk   (clk),
    .en    (en),
    .x_in  (OPW'(sd.cr)),
    .y_in  (OPW'(sd.sr)),
    .z_out (zr)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_chan.valid;
      for (int k = 1; k < DEPTH; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      out_valid_r <= vld_r[DEPTH-1];
    end
  end

  // result register
  angle_t roll_r, yaw_r, pitch_full;
  pitch_t pitch_r;
  logic   clamp_r;

  always_comb begin
    if (flag_r[CLAT-1].clamp) begin
      pitch_full = flag_r[CLAT-1].dir ? HALF_PI_Q13 : -HALF_PI_Q13;
    end else begin
      pitch_full = to_q13(zp, HALF_PI_Q13);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roll_r  <= to_q13(zr, PI_Q13);
      yaw_r   <= to_q13(zy, PI_Q13);
      pitch_r <= pitch_full[PITCH_W-1:0];
      clamp_r <= flag_r[CLAT-1].clamp;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.roll_angle    = roll_r;
  assign out_chan.pitch_angle   = pitch_r;
  assign out_chan.yaw_angle     = yaw_r;
  assign out_chan.pitch_clamped = clamp_r;

endmodule

/* bench/qte_tb_checker.sv */
// result checker: predicts euler angles from accepted quaternions and compares
`timescale 1ns / 100ps
module qte_tb_checker #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic   clk,
  input  logic   rst_n,
  qte_in_if.sink in_mon,
  qte_out_if.sink out_mon,
  output int     fail_count,
  output int     pending_count
);
  import qte_pkg::*;

  typedef struct packed {
    angle_t roll;
    pitch_t pitch;
    angle_t yaw;
    logic   clamp;
  } euler_t;

  localparam longint UNIT_Q28 = 64'sd268435456;
  localparam longint HALF_PI_LIM = 12868;
  localparam longint PI_LIM = 25736;

  euler_t angle_queue[$];

  function automatic longint floor_shr(longint v, int k);
    return v >>> k;
  endfunction

  function automatic longint vector_angle(longint sv, longint cv);
    longint acc;
    longint xs;
    longint ys;
    int steps;
    acc = 0;
    steps = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
    if (sv == 0 && cv == 0) return 0;
    if (cv < 0) begin
      acc = (sv >= 0) ? longint'(PI_Q30) : -longint'(PI_Q30);
      cv = -cv;
      sv = -sv;
    end
    for (int i = 0; i < steps; i++) begin
      xs = floor_shr(cv, i);
      ys = floor_shr(sv, i);
      if (sv >= 0) begin
        cv = cv + ys;
        sv = sv - xs;
        acc = acc + longint'(ATAN_TAB[i]);
      end else begin
        cv = cv - ys;
        sv = sv + xs;
        acc = acc - longint'(ATAN_TAB[i]);
      end
    end
    return acc;
  endfunction

  function automatic longint rad_q13(longint a, longint lim);
    longint r;
    r = floor_shr(a + 65536, 17);
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned bitv;
    rem = n;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(root);
  endfunction

  function automatic euler_t predict_euler(quat_t qx, quat_t qy, quat_t qz, quat_t qw);
    longint x;
    longint y;
    longint z;
    longint w;
    longint sp;
    longint p;
    longint unsigned sq;
    euler_t e;
    x = qx;
    y = qy;
    z = qz;
    w = qw;
    sp = 2 * (w * y - z * x);
    e.clamp = 1'b0;
    if (sp >= UNIT_Q28 || sp <= -UNIT_Q28) begin
      p = (sp > 0) ? HALF_PI_LIM : -HALF_PI_LIM;
      e.clamp = 1'b1;
    end else begin
      sq = longint'(sp * sp);
      p = rad_q13(vector_angle(sp, int_sqrt((64'd1 << 56) - sq)), HALF_PI_LIM);
    end
    e.pitch = pitch_t'(p);
    e.yaw = angle_t'(rad_q13(vector_angle(2 * (w * z + x * y),
                                          UNIT_Q28 - 2 * (y * y + z * z)), PI_LIM));
    e.roll = angle_t'(rad_q13(vector_angle(2 * (w * x + y * z),
                                           UNIT_Q28 - 2 * (x * x + y * y)), PI_LIM));
    return e;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  initial fail_count = 0;
  initial pending_count = 0;

  always @(posedge clk) begin
    euler_t want;
    if (rst_n && in_mon.valid && in_mon.ready) begin
      angle_queue.push_back(predict_euler(in_mon.quat_x, in_mon.quat_y,
                                          in_mon.quat_z, in_mon.quat_w));
    end
    if (rst_n && out_mon.valid && out_mon.ready) begin
      if (angle_queue.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = angle_queue.pop_front();
        if (out_mon.roll_angle !== want.roll)
          report_mismatch("roll", out_mon.roll_angle, want.roll);
        if (out_mon.pitch_angle !== want.pitch)
          report_mismatch("pitch", out_mon.pitch_angle, want.pitch);
        if (out_mon.yaw_angle !== want.yaw)
          report_mismatch("yaw", out_mon.yaw_angle, want.yaw);
        if (out_mon.pitch_clamped !== want.clamp)
          report_mismatch("clamp", out_mon.pitch_clamped, want.clamp);
      end
    end
    pending_count = angle_queue.size();
  end
endmodule

/* bench/testbench.sv */
// stimulus and verdict for the quaternion to euler converter
`timescale 1ns / 100ps
module testbench;
  import qte_pkg::*;

  localparam int LATENCY = 16 + 35;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending_count;
  int   src_idle_pct;
  int   dst_idle_pct;
  int   hold_cycles;

  qte_in_if  in_chan();
  qte_out_if out_chan();

  quaternion_to_euler_core #(.CORDIC_ITERATIONS(16)) dut (
    .clk(clk), .rst_n(rst_n), .in_chan(in_chan), .out_chan(out_chan)
  );

  qte_tb_checker #(.CORDIC_ITERATIONS(16)) checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_chan), .out_mon(out_chan),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  // receiver: random stalls, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_chan.ready <= 1'b0;
    end else begin
      out_chan.ready <= ($urandom_range(99) >= dst_idle_pct);
    end
  end

  task automatic send_quat(quat_t qx, quat_t qy, quat_t qz, quat_t qw);
    while ($urandom_range(99) < src_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.quat_x <= qx;
    in_chan.quat_y <= qy;
    in_chan.quat_z <= qz;
    in_chan.quat_w <= qw;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic quat_t rand_comp(int mode);
    int c;
    c = $urandom_range(3);
    if (mode == 0) return quat_t'($urandom);
    if (c == 0) return quat_t'($urandom);
    // mostly near-unit quaternion components
    return quat_t'($signed($urandom_range(2 * 11585)) - 11585);
  endfunction

  task automatic send_random(int n);
    int mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(3);
      send_quat(rand_comp(mode), rand_comp(mode), rand_comp(mode), rand_comp(mode));
    end
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
  endtask

  initial begin
    int guard;
    rst_n = 1'b0;
    hold_cycles = 0;
    src_idle_pct = 0;
    dst_idle_pct = 0;
    in_chan.valid = 1'b0;
    in_chan.quat_x = '0;
    in_chan.quat_y = '0;
    in_chan.quat_z = '0;
    in_chan.quat_w = '0;
    out_chan.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd16384);
    send_quat(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd16384, 16'sd0, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
    send_quat(16'sd0, 16'sd0, 16'sd16384, 16'sd0);
    send_quat(16'sd0, 16'sd11585, 16'sd0, 16'sd11585);
    send_quat(16'sd0, -16'sd11585, 16'sd0, 16'sd11585);
    send_quat(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
    send_quat(16'sd0, 16'sd0, 16'sd11585, -16'sd11585);
    send_quat(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_quat(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767);
    send_quat(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768);
    send_quat(-16'sd32768, 16'sd32767, 16'sd0, 16'sd1);
    send_quat(16'sd0, 16'sd8192, 16'sd0, 16'sd8192);
    send_quat(16'sd1, -16'sd1, 16'sd1, -16'sd1);
    send_quat(16'sd0, 16'sd11586, 16'sd0, 16'sd11586);
    send_quat(16'sd5000, 16'sd6000, -16'sd7000, 16'sd10000);
    drain();

    src_idle_pct = 19;
    dst_idle_pct = 68;
    send_random(500);
    // long receiver hold-off while items keep coming
    src_idle_pct = 0;
    hold_cycles <= 300;
    send_random(100);
    drain();

    src_idle_pct = 68;
    dst_idle_pct = 19;
    send_random(500);
    drain();

    src_idle_pct = 0;
    dst_idle_pct = 0;
    send_random(600);
    drain();

    guard = 0;
    while (guard < LATENCY + 20) begin
      @(negedge clk);
      guard++;
    end
    if (fail_count == 0 && pending_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
